// ===== hdl/mpl_pkg.sv =====
// ----------------------------------------------------------------------------
// mpl_pkg: shared types and constants for the mesh point locator
// Request codes, register indexes and the walker-to-tester control struct.
// ----------------------------------------------------------------------------
package mpl_pkg;

    localparam int REQ_BITS = 2;
    localparam logic [1:0] REQ_VERTEX   = 2'd0;
    localparam logic [1:0] REQ_TRIANGLE = 2'd1;
    localparam logic [1:0] REQ_QUERY    = 2'd2;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 20;
    localparam logic [0:0] REG_TRIANGLE_COUNT = 1'd0;
    localparam logic [0:0] REG_AREA_TOLERANCE = 1'd1;

    localparam int COUNT_BITS = 11;
    localparam int TOL_BITS   = 20;
    localparam int SLOT_BITS  = 10;
    localparam int FIELD_BITS = 24;

    // control passed alongside the vertex data from the walker
    typedef struct packed {
        logic valid;
        logic last;
    } tri_ctl_t;

endpackage

// ===== hdl/mpl_area_test.sv =====
// ----------------------------------------------------------------------------
// mpl_area_test: pipelined containment test for one triangle per cycle
// Differences, products, cross-product magnitudes, the area difference and the
// tolerance compare, each in a register stage of its own.
// ----------------------------------------------------------------------------
module mpl_area_test
    import mpl_pkg::*;
#(
    parameter int CB = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tri_ctl_t            in_ctl,
    input  logic signed [CB-1:0] x1,
    input  logic signed [CB-1:0] y1,
    input  logic signed [CB-1:0] x2,
    input  logic signed [CB-1:0] y2,
    input  logic signed [CB-1:0] x3,
    input  logic signed [CB-1:0] y3,
    input  logic signed [CB-1:0] px,
    input  logic signed [CB-1:0] py,
    input  logic [TOL_BITS-1:0] tol,
    output tri_ctl_t            out_ctl,
    output logic                hit,
    output logic                busy
);
    localparam int DB = CB + 1;
    localparam int PB = 2 * DB;
    localparam int AB = PB + 1;
    localparam int SB = AB + 3;

    tri_ctl_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    logic signed [DB-1:0] d_reg [12];
    logic signed [PB-1:0] p_reg [8];
    logic [AB-1:0] a_reg [4];
    logic [SB-1:0] dif_reg;
    logic hit_reg;

    logic signed [AB-1:0] cr [4];
    logic [SB-1:0] sum_w, at_w, dd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
        end
        else
        begin
            c1_reg <= in_ctl;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            c4_reg <= c3_reg;
            c5_reg <= c4_reg;
        end
    end

    // edge vectors: tri(1,2,3), (1,2,p), (3,2,p), (1,3,p)
    always_ff @(posedge clk)
    begin
        d_reg[0]  <= DB'(x3) - DB'(x1);
        d_reg[1]  <= DB'(y2) - DB'(y1);
        d_reg[2]  <= DB'(x2) - DB'(x1);
        d_reg[3]  <= DB'(y3) - DB'(y1);
        d_reg[4]  <= DB'(px) - DB'(x1);
        d_reg[5]  <= DB'(py) - DB'(y1);
        d_reg[6]  <= DB'(px) - DB'(x3);
        d_reg[7]  <= DB'(y2) - DB'(y3);
        d_reg[8]  <= DB'(x2) - DB'(x3);
        d_reg[9]  <= DB'(py) - DB'(y3);
        d_reg[10] <= DB'(y3) - DB'(y1);
        d_reg[11] <= DB'(x3) - DB'(x1);
    end

    always_ff @(posedge clk)
    begin
        p_reg[0] <= d_reg[0] * d_reg[1];
        p_reg[1] <= d_reg[2] * d_reg[3];
        p_reg[2] <= d_reg[4] * d_reg[1];
        p_reg[3] <= d_reg[2] * d_reg[5];
        p_reg[4] <= d_reg[6] * d_reg[7];
        p_reg[5] <= d_reg[8] * d_reg[9];
        p_reg[6] <= d_reg[4] * d_reg[10];
        p_reg[7] <= d_reg[11] * d_reg[5];
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            cr[i] = AB'(p_reg[2*i]) - AB'(p_reg[2*i+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            a_reg[i] <= cr[i][AB-1] ? AB'(-cr[i]) : AB'(cr[i]);
        end
    end

    assign sum_w = SB'(a_reg[1]) + SB'(a_reg[2]) + SB'(a_reg[3]);
    assign at_w  = SB'(a_reg[0]);

    always_ff @(posedge clk)
    begin
        dif_reg <= (sum_w >= at_w) ? sum_w - at_w : at_w - sum_w;
    end

    assign dd = SB'(tol);

    always_ff @(posedge clk)
    begin
        hit_reg <= (dif_reg <= dd);
    end

    // control travels with hit; busy covers every stage
    assign out_ctl = c5_reg;
    assign hit     = hit_reg;
    assign busy    = c1_reg.valid || c2_reg.valid || c3_reg.valid || c4_reg.valid
                     || c5_reg.valid;

endmodule

// ===== hdl/mpl_mesh_store.sv =====
// ----------------------------------------------------------------------------
// mpl_mesh_store: vertex and triangle memories
// Triangle corners are read first, then three vertex ports in the next cycle.
// ----------------------------------------------------------------------------
module mpl_mesh_store
    import mpl_pkg::*;
#(
    parameter int NT = 1024,
    parameter int NV = 1024,
    parameter int CB = 24
)
(
    input  logic                    clk,
    input  logic                    vwr,
    input  logic [$clog2(NV)-1:0]   vaddr,
    input  logic [2*CB-1:0]         vdata,
    input  logic                    twr,
    input  logic [$clog2(NT)-1:0]   twaddr,
    input  logic [3*$clog2(NV)-1:0] tdata_w,
    input  logic [$clog2(NT)-1:0]   traddr,
    output logic [2*CB-1:0]         v1,
    output logic [2*CB-1:0]         v2,
    output logic [2*CB-1:0]         v3
);
    localparam int VB = $clog2(NV);

    logic [3*VB-1:0] tri_mem [NT];
    logic [2*CB-1:0] vm1 [NV];
    logic [2*CB-1:0] vm2 [NV];
    logic [2*CB-1:0] vm3 [NV];
    logic [3*VB-1:0] trd_reg;

    always_ff @(posedge clk)
    begin
        if (twr)
        begin
            tri_mem[twaddr] <= tdata_w;
        end
        trd_reg <= tri_mem[traddr];
    end

    // three copies of the vertex memory give three read ports
    always_ff @(posedge clk)
    begin
        if (vwr)
        begin
            vm1[vaddr] <= vdata;
            vm2[vaddr] <= vdata;
            vm3[vaddr] <= vdata;
        end
        v1 <= vm1[trd_reg[VB-1:0]];
        v2 <= vm2[trd_reg[2*VB-1:VB]];
        v3 <= vm3[trd_reg[3*VB-1:2*VB]];
    end

endmodule

// ===== hdl/mesh_point_locate.sv =====
// ----------------------------------------------------------------------------
// mesh_point_locate: point-in-triangle search over a stored mesh
// Loads vertices and triangles, walks triangles for each query point.
// ----------------------------------------------------------------------------
// channel | dir | contents
// s_axis  | in  | tdata: req_type, slot_index, coord_x, coord_y, corners a,b,c
// m_axis  | out | tdata: found, hit_triangle
// cfg     | in  | wr_en, wr_index, wr_data (0 triangle_count, 1 area_tolerance)
// A load is written as it is accepted, and the input stays ready. A query issues
// one triangle per cycle from the triangle memory; two memory reads and five
// test stages lie between issue and hit, and issuing stops early on a hit (the
// pipeline still drains).
// Reset clears control, result and configuration registers; memories are undefined until loaded.
// A result waits in the output register while m_axis_tready is low.
// ----------------------------------------------------------------------------
module mesh_point_locate
    import mpl_pkg::*;
#(
    parameter int MAX_TRIANGLES = 1024,
    parameter int MAX_VERTICES  = 1024,
    parameter int COORD_BITS    = 24
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // req_type[1:0], slot_index[11:2], coord_x[35:12], coord_y[59:36],
    // corner_a[69:60], corner_b[79:70], corner_c[89:80]
    input  logic [95:0]              s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // found[0], hit_triangle[10:1]
    output logic [15:0]              m_axis_tdata,
    input  logic                     wr_en,
    input  logic [CFG_IDX_BITS-1:0]  wr_index,
    input  logic [CFG_DATA_BITS-1:0] wr_data
);
    localparam int TB = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CB = COORD_BITS;
    localparam int KB = TB + 1;
    localparam longint unsigned NV_RECIP =
        ((64'd1 << 32) + 64'(MAX_VERTICES) - 64'd1) / 64'(MAX_VERTICES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t state_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [TOL_BITS-1:0]   tol_reg;
    logic signed [CB-1:0]  px_reg, py_reg;
    logic [KB-1:0] issue_reg, n_reg;
    logic [KB-1:0] tag_pipe [7];
    tri_ctl_t      ctl_pipe [2];
    logic          found_reg;
    logic [SLOT_BITS-1:0] hit_reg;
    logic          out_v_reg;

    logic [1:0]  req_type;
    logic [9:0]  slot_index, ca, cb_i, cc;
    logic [FIELD_BITS-1:0] cx, cy;
    logic s_acc, m_acc;
    logic [2*CB-1:0] v1, v2, v3;
    tri_ctl_t issue_ctl, t_out, tst_mid;
    logic t_hit;
    logic tst_busy;
    logic [KB-1:0] cnt_clip;

    // reduce a corner index modulo MAX_VERTICES by reciprocal multiplication
    function automatic logic [VB-1:0] corner_wrap(input logic [9:0] v);
        logic [41:0] prod;
        logic [31:0] rem;
        prod = 42'(v) * 42'(NV_RECIP);
        rem  = 32'(v) - 32'(prod[41:32]) * 32'(MAX_VERTICES);
        return VB'(rem);
    endfunction

    assign req_type   = s_axis_tdata[1:0];
    assign slot_index = s_axis_tdata[11:2];
    assign cx         = s_axis_tdata[35:12];
    assign cy         = s_axis_tdata[59:36];
    assign ca         = s_axis_tdata[69:60];
    assign cb_i       = s_axis_tdata[79:70];
    assign cc         = s_axis_tdata[89:80];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    assign cnt_clip = (32'(count_reg) > MAX_TRIANGLES) ? KB'(MAX_TRIANGLES)
                                                       : KB'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            tol_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_TRIANGLE_COUNT: count_reg <= wr_data[COUNT_BITS-1:0];
                REG_AREA_TOLERANCE: tol_reg   <= wr_data[TOL_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign issue_ctl.valid = (state_reg == ST_RUN) && (issue_reg < n_reg) && !found_reg;
    assign issue_ctl.last  = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            issue_reg <= '0;
            n_reg     <= '0;
            found_reg <= 1'b0;
            hit_reg   <= '0;
            out_v_reg <= 1'b0;
            ctl_pipe[0] <= '0;
            ctl_pipe[1] <= '0;
        end
        else
        begin
            ctl_pipe[0] <= issue_ctl;
            ctl_pipe[1] <= ctl_pipe[0];
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_acc && req_type == REQ_QUERY)
                    begin
                        state_reg <= ST_RUN;
                        issue_reg <= '0;
                        n_reg     <= cnt_clip;
                        found_reg <= 1'b0;
                        hit_reg   <= '0;
                    end
                end
                ST_RUN:
                begin
                    if (issue_ctl.valid)
                    begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                    if (t_out.valid && t_hit && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        hit_reg   <= SLOT_BITS'(tag_pipe[6]);
                    end
                    // drained: nothing issued or in flight
                    if (!issue_ctl.valid && !ctl_pipe[0].valid && !ctl_pipe[1].valid
                        && !tst_busy)
                    begin
                        state_reg <= ST_OUT;
                        out_v_reg <= 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (m_acc)
                    begin
                        out_v_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // tags follow the issue through memory reads and the test pipeline
    always_ff @(posedge clk)
    begin
        tag_pipe[0] <= issue_reg;
        for (int i = 1; i < 7; i++)
        begin
            tag_pipe[i] <= tag_pipe[i-1];
        end
        if (s_acc && req_type == REQ_QUERY)
        begin
            px_reg <= CB'(cx);
            py_reg <= CB'(cy);
        end
    end

    mpl_mesh_store #(.NT(MAX_TRIANGLES), .NV(MAX_VERTICES), .CB(CB)) u_store (
        .clk     (clk),
        .vwr     (s_acc && req_type == REQ_VERTEX && 32'(slot_index) < MAX_VERTICES),
        .vaddr   (VB'(slot_index)),
        .vdata   ({CB'(cy), CB'(cx)}),
        .twr     (s_acc && req_type == REQ_TRIANGLE && 32'(slot_index) < MAX_TRIANGLES),
        .twaddr  (TB'(slot_index)),
        .tdata_w ({corner_wrap(cc), corner_wrap(cb_i), corner_wrap(ca)}),
        .traddr  (TB'(issue_reg)),
        .v1      (v1),
        .v2      (v2),
        .v3      (v3)
    );

    mpl_area_test #(.CB(CB)) u_test (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (ctl_pipe[1]),
        .x1      (v1[CB-1:0]),
        .y1      (v1[2*CB-1:CB]),
        .x2      (v2[CB-1:0]),
        .y2      (v2[2*CB-1:CB]),
        .x3      (v3[CB-1:0]),
        .y3      (v3[2*CB-1:CB]),
        .px      (px_reg),
        .py      (py_reg),
        .tol     (tol_reg),
        .out_ctl (tst_mid),
        .hit     (t_hit),
        .busy    (tst_busy)
    );

    assign t_out = tst_mid;

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {5'd0, hit_reg, found_reg};

    a_tready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while result pending");
    a_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[10:1] == '0)
        else $error("miss with nonzero index");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule
